// ===== hw/rtl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
`default_nettype none
package ffba_pkg;
   localparam int unsigned ADDR_W = 24;
   localparam int unsigned STATUS_W = 2;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

   localparam logic [ADDR_W-1:0] POOL_BYTES_RESET = 24'd65536;

   typedef struct packed {
      logic                action;
      logic [ADDR_W-1:0]   request_bytes;
      logic [ADDR_W-1:0]   free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   result_address;
      logic [STATUS_W-1:0] status;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/ffba_req_if.sv =====
// Valid/ready channel carrying allocator requests.
`default_nettype none
interface ffba_req_if;
   logic              valid;
   logic              ready;
   ffba_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffba_rsp_if.sv =====
// Valid/ready channel carrying allocator responses.
`default_nettype none
interface ffba_rsp_if;
   logic              valid;
   logic              ready;
   ffba_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit block allocator: an allocate or free works through one write port and
// one registered read port on the segment table: it scans the table entry by entry,
// then shifts entries up or down to insert a split remainder or remove merged
// segments. Reset and a write of csr_wdata both load the table as a single free
// segment (entries beyond the count are never used); reset uses a pool of 65536
// bytes. The request side is not ready while a request is in progress, while its
// response waits or while csr_we is high.
`default_nettype none
module first_fit_block_allocator #(
   parameter int unsigned MAX_SEGMENTS = 64,
   parameter int unsigned HEADER_BYTES = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   ffba_req_if.sink        req,
   ffba_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire logic [ffba_pkg::ADDR_W-1:0] csr_wdata
);
   localparam int unsigned AW = ffba_pkg::ADDR_W;
   localparam int unsigned IW = $clog2(MAX_SEGMENTS);
   localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned EW = 2 * AW + 1;
   localparam logic [AW:0] HDR = (AW + 1)'(HEADER_BYTES);
   localparam logic [AW-1:0] HDR3 = AW'(3 * HEADER_BYTES);
   localparam logic [AW-1:0] HDR2 = AW'(2 * HEADER_BYTES);
   localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD    = 8'b00000010,
      S_CHK   = 8'b00000100,
      S_SHR   = 8'b00001000,
      S_SHRW  = 8'b00010000,
      S_MRG   = 8'b00100000,
      S_SHL   = 8'b01000000,
      S_RESP  = 8'b10000000
   } state_type;

   // Entry layout: {used, start, size}.
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        hit_ff, hit_in;
   logic [CW-1:0]        rmv_ff, rmv_in;
   logic [1:0]           phase_ff, phase_in;
   ffba_pkg::req_type    op_ff, op_in;
   ffba_pkg::rsp_type    out_ff, out_in;
   logic [EW-1:0]        cur_ff, cur_in;
   logic [EW-1:0]        prev_ff, prev_in;
   logic                 prev_ok_ff, prev_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 wr_en;
   logic [IW-1:0]        wr_idx, rd_idx;
   logic [EW-1:0]        wr_data, rd_data;
   logic [AW:0]          need, sum;
   logic [AW-1:0]        pool_bytes;

   ffba_table #(.DEPTH(MAX_SEGMENTS), .IDX_W(IW)) u_table (
      .clock, .wr_en, .wr_idx, .wr_data, .rd_idx, .rd_data
   );

   assign req.ready   = (state_ff == S_IDLE) && !rsp_valid_ff && !csr_we;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = out_ff;
   assign need = {1'b0, op_ff.request_bytes} + HDR;
   assign pool_bytes = reset ? ffba_pkg::POOL_BYTES_RESET : csr_wdata;
   // One shared adder serves the free-address match, split start and merges.
   always_comb begin
      case (state_ff)
         S_SHR:   sum = {1'b0, cur_ff[2*AW-1:AW]} + need;
         S_MRG: begin
            if (phase_ff == 2'd1) begin
               sum = {1'b0, cur_ff[AW-1:0]} + HDR + {1'b0, rd_data[AW-1:0]};
            end else begin
               sum = {1'b0, prev_ff[AW-1:0]} + HDR + {1'b0, cur_ff[AW-1:0]};
            end
         end
         default: sum = {1'b0, rd_data[2*AW-1:AW]} + HDR;
      endcase
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; hit_in = hit_ff;
      rmv_in = rmv_ff; phase_in = phase_ff; op_in = op_ff; out_in = out_ff;
      cur_in = cur_ff; prev_in = prev_ff; prev_ok_in = prev_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      wr_en = 1'b0; wr_idx = IW'(0); wr_data = '0; rd_idx = idx_ff[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.payload; idx_in = '0; prev_ok_in = 1'b0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               out_in.result_address = '0;
               out_in.status = (op_ff.action == ffba_pkg::ACTION_ALLOC) ?
                  ffba_pkg::STATUS_NO_FIT : ffba_pkg::STATUS_IGNORED;
               state_in = S_RESP;
            end else begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cur_in = rd_data;
            if (op_ff.action == ffba_pkg::ACTION_ALLOC) begin
               if (!rd_data[EW-1] && {1'b0, rd_data[AW-1:0]} >= need) begin
                  if (count_ff >= CMAX) begin
                     out_in.result_address = '0;
                     out_in.status = ffba_pkg::STATUS_NO_FIT;
                     state_in = S_RESP;
                  end else begin
                     hit_in = idx_ff; idx_in = count_ff; state_in = S_SHR;
                  end
               end else begin
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end else begin
               if (rd_data[EW-1] && sum == {1'b0, op_ff.free_address}) begin
                  hit_in = idx_ff; phase_in = 2'd0;
                  idx_in = idx_ff + CW'(1); state_in = S_MRG;
               end else begin
                  prev_in = rd_data; prev_ok_in = 1'b1;
                  idx_in = idx_ff + CW'(1); state_in = S_RD;
               end
            end
         end
         S_SHR: begin
            // Move entries up one place, from the top down to hit+1.
            if (idx_ff > hit_ff + CW'(1)) begin
               rd_idx = IW'(idx_ff - CW'(1)); state_in = S_SHRW;
            end else begin
               wr_en = 1'b1; wr_idx = IW'(hit_ff + CW'(1));
               wr_data = {1'b0, sum[AW-1:0], cur_ff[AW-1:0] - need[AW-1:0]};
               phase_in = 2'd3; state_in = S_SHRW;
            end
         end
         S_SHRW: begin
            if (phase_ff == 2'd3) begin
               wr_en = 1'b1; wr_idx = IW'(hit_ff);
               wr_data = {1'b1, cur_ff[2*AW-1:AW], op_ff.request_bytes};
               count_in = count_ff + CW'(1); phase_in = 2'd0;
               out_in.result_address = cur_ff[2*AW-1:AW] + HDR[AW-1:0];
               out_in.status = ffba_pkg::STATUS_ALLOCATED;
               state_in = S_RESP;
            end else begin
               wr_en = 1'b1; wr_idx = IW'(idx_ff); wr_data = rd_data;
               idx_in = idx_ff - CW'(1); state_in = S_SHR;
            end
         end
         S_MRG: begin
            // phase 0: issue read of next; 1: merge with next; 2: merge with previous.
            case (phase_ff)
               2'd0: begin
                  cur_in[EW-1] = 1'b0;
                  if (idx_ff < count_ff) phase_in = 2'd1;
                  else phase_in = 2'd2;
               end
               2'd1: begin
                  phase_in = 2'd2;
                  if (!rd_data[EW-1]) begin
                     // Fold the free next entry into the freed one, then remove it.
                     cur_in = {1'b0, cur_ff[2*AW-1:AW], sum[AW-1:0]};
                     rmv_in = hit_ff + CW'(1); phase_in = 2'd1;
                     idx_in = CW'(0); state_in = S_SHL;
                  end
               end
               default: begin
                  if (hit_ff != '0 && prev_ok_ff && !prev_ff[EW-1]) begin
                     cur_in = {1'b0, prev_ff[2*AW-1:AW], sum[AW-1:0]};
                     rmv_in = hit_ff; hit_in = hit_ff - CW'(1);
                     phase_in = 2'd2; idx_in = CW'(1); state_in = S_SHL;
                  end else begin
                     wr_en = 1'b1; wr_idx = IW'(hit_ff); wr_data = cur_ff;
                     out_in.result_address = '0;
                     out_in.status = ffba_pkg::STATUS_FREED;
                     state_in = S_RESP;
                  end
               end
            endcase
         end
         S_SHL: begin
            // Write the merged entry, then pull entries after rmv down one place.
            if (idx_ff == CW'(0) || idx_ff == CW'(1)) begin
               wr_en = 1'b1; wr_idx = IW'(hit_ff); wr_data = cur_ff;
               rd_idx = IW'(rmv_ff + CW'(1));
               prev_ok_in = prev_ok_ff;
               idx_in = (idx_ff == CW'(1)) ? CW'(3) : CW'(2);
            end else if (rmv_ff + CW'(1) < count_ff) begin
               wr_en = 1'b1; wr_idx = IW'(rmv_ff); wr_data = rd_data;
               rd_idx = IW'(rmv_ff + CW'(2));
               rmv_in = rmv_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
               if (idx_ff == CW'(2) && hit_ff != '0) begin
                  // After merging with next, try the previous neighbour.
                  phase_in = 2'd2; state_in = S_MRG;
               end else begin
                  out_in.result_address = '0;
                  out_in.status = ffba_pkg::STATUS_FREED;
                  state_in = S_RESP;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // Reset and a pool write both load the table as one free segment.
      if (reset || csr_we) begin
         wr_en = 1'b1; wr_idx = IW'(0);
         wr_data = {1'b0, HDR2, (pool_bytes > HDR3) ? pool_bytes - HDR3 : AW'(0)};
         count_in = CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; count_ff <= CW'(1);
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in; count_ff <= count_in;
      end
      idx_ff <= idx_in; hit_ff <= hit_in; rmv_ff <= rmv_in; phase_ff <= phase_in;
      op_ff <= op_in; out_ff <= out_in; cur_ff <= cur_in; prev_ff <= prev_in;
      prev_ok_ff <= prev_ok_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMAX) else $error("segment count exceeds table depth");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("response pending while busy");
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> state_ff == S_RD) else $error("request not started");
endmodule
`default_nettype wire

// ===== hw/rtl/ffba_table.sv =====
// Segment table memory: one write port and one registered read port.
`default_nettype none
module ffba_table #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned IDX_W = 6
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [IDX_W-1:0]            wr_idx,
   input  wire logic [2*ffba_pkg::ADDR_W:0] wr_data,
   input  wire logic [IDX_W-1:0]            rd_idx,
   output      logic [2*ffba_pkg::ADDR_W:0] rd_data
);
   logic [2*ffba_pkg::ADDR_W:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data <= mem[rd_idx];
   end
endmodule
`default_nettype wire
